@@ hdl/rrss_pkg.sv @@
// Package for the ramped-rate spawn scheduler: constants, request codes, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package rrss_pkg;
  localparam int MaxSpawnsDefault = 16;
  localparam logic [31:0] MaxStepReset = 32'h0100_0000;
  localparam logic [16:0] EpsUnits = 17'd85899;

  typedef enum logic [1:0] {
    REQ_RESET = 2'd0,
    REQ_RAMP  = 2'd1,
    REQ_EMPTY = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_BIRTH, ST_DIV1, ST_SQRT, ST_DEN, ST_DIV2, ST_EMIT
  } state_t;

  // divider request to the shared restoring divider
  typedef struct packed {
    logic        start;
    logic [94:0] num;
    logic [31:0] den;
  } div_req_t;
endpackage

@@ hdl/rrss_if.sv @@
// Valid/ready channel interfaces for the scheduler.
// Depends on nothing.
`timescale 1ns / 1ps
interface rrss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        first_step;
  logic [31:0] dt;
  logic [23:0] start_rate;
  logic [23:0] end_rate;
  logic [31:0] duration;
  modport source(output valid, req_type, first_step, dt, start_rate, end_rate, duration,
                 input ready);
  modport sink(input valid, req_type, first_step, dt, start_rate, end_rate, duration,
               output ready);
endinterface

interface rrss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] spawn_age;
  logic        last_of_run;
  modport source(output valid, spawn_age, last_of_run, input ready);
  modport sink(input valid, spawn_age, last_of_run, output ready);
endinterface

interface rrss_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ hdl/rrss_div.sv @@
// Shared restoring divider, one quotient bit per cycle; also runs the integer square root.
// Depends on rrss_pkg.
`timescale 1ns / 1ps
module rrss_div (
  input  logic              clk,
  input  logic              rst,
  input  rrss_pkg::div_req_t req,
  input  logic              sqrt_start,
  input  logic [63:0]       sqrt_val,
  output logic              busy,
  output logic [94:0]       quo,
  output logic [31:0]       rem,
  output logic [63:0]       root
);
  import rrss_pkg::*;

  logic [6:0]  count;
  logic        mode_sqrt;
  logic [94:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic [63:0] sv;
  logic [63:0] sres;
  logic [63:0] sbit;
  logic [32:0] r_shift;
  logic [64:0] trial;

  assign r_shift = {r[31:0], q[94]};
  assign trial = {1'b0, sres} + {1'b0, sbit};

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mode_sqrt <= 1'b0;
    end else if (req.start) begin
      count <= 7'd95;
      mode_sqrt <= 1'b0;
      q <= req.num;
      r <= '0;
      d <= req.den;
    end else if (sqrt_start) begin
      count <= 7'd32;
      mode_sqrt <= 1'b1;
      sv <= sqrt_val;
      sres <= '0;
      sbit <= 64'h4000_0000_0000_0000;
    end else if (count != '0) begin
      count <= count - 7'd1;
      if (mode_sqrt) begin
        if ({1'b0, sv} >= trial) begin
          sv <= sv - trial[63:0];
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end else begin
        if (r_shift >= {1'b0, d}) begin
          r <= r_shift - {1'b0, d};
          q <= {q[93:0], 1'b1};
        end else begin
          r <= r_shift;
          q <= {q[93:0], 1'b0};
        end
      end
    end
  end

  assign busy = (count != '0);
  assign quo = q;
  assign rem = r[31:0];
  assign root = sres;
endmodule

@@ hdl/ramped_rate_spawn_scheduler.sv @@
// Ramped-rate spawn scheduler, top level.
// A step with no births returns to idle; a valid ramp runs, per birth, a divide for the
// discriminant term, a square root and a divide for the birth time on the shared unit in
// rrss_div, skipping the second divide when the denominator is zero. Not ready while a
// step is in work; a stalled result holds the next birth. Depends on rrss_pkg, rrss_if, rrss_div.
// Synchronous reset clears the sequencer and cross-step state; max_step_time resets to 1.0 s.
`timescale 1ns / 1ps
module ramped_rate_spawn_scheduler #(
  parameter int MAX_SPAWNS = rrss_pkg::MaxSpawnsDefault
) (
  input logic clk,
  input logic rst,
  rrss_cfg_if.sink cfg,
  rrss_in_if.sink  step,
  rrss_out_if.source spawn
);
  import rrss_pkg::*;

  localparam int CW = $clog2(MAX_SPAWNS + 1);

  state_t state, state_next;
  logic [31:0] max_step_time;
  logic [23:0] birth_fraction;
  logic [31:0] elapsed_time;
  logic [CW-1:0] spawn_count;
  logic update_valid;
  logic [31:0] held_dt;

  // step operands
  logic [23:0] s_r, e_r, prev;
  logic [31:0] d_r;
  logic [1:0] in_type;
  logic [CW-1:0] limit, idx;
  logic [63:0] disc;
  logic [32:0] den;
  logic [31:0] age;
  logic out_valid;
  logic last_r;

  div_req_t dreq;
  logic sq_start, dbusy;
  logic [94:0] quo;
  logic [31:0] rem;
  logic [63:0] root;

  rrss_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .sqrt_start(sq_start), .sqrt_val(disc),
    .busy(dbusy), .quo(quo), .rem(rem), .root(root)
  );

  // combinational helpers
  logic [24:0] sum_se;
  logic [57:0] prod;
  logic [58:0] acc;
  logic [25:0] whole;
  logic [59:0] n_val;
  logic [23:0] diff;
  logic [83:0] num_d1;
  logic [47:0] s2;
  logic [63:0] term_c;
  logic [32:0] at;
  logic [32:0] el_sum;
  logic [CW-1:0] lim_c;

  assign sum_se = {1'b0, s_r} + {1'b0, e_r};
  assign prod = {33'd0, sum_se} * {26'd0, d_r};
  assign acc = {1'b0, prod} + {26'd0, prev, 9'd0};
  assign whole = 26'(({1'b0, acc} + {43'd0, EpsUnits}) >> 33);
  assign lim_c = (whole < 26'(MAX_SPAWNS)) ? CW'(whole) : CW'(MAX_SPAWNS);
  assign n_val = 60'h100_0000 - {36'd0, prev} + ({{(60-CW){1'b0}}, idx} << 24);
  assign diff = (e_r >= s_r) ? e_r - s_r : s_r - e_r;
  // the birth target stays below 2^31, so its low word is enough
  assign num_d1 = {60'd0, diff} * {52'd0, n_val[31:0]};
  assign s2 = s_r * s_r;
  assign el_sum = {1'b0, elapsed_time} + {1'b0, d_r};
  // term from the first quotient and its remainder fraction
  always_comb begin
    if (quo >= (95'd1 << 62)) term_c = 64'h4000_0000_0000_0000;
    else begin
      term_c = quo[63:0];
      if (term_c > 64'h4000_0000_0000_0000) term_c = 64'h4000_0000_0000_0000;
    end
  end

  // discriminant, clamped at zero for a falling ramp
  always_comb begin
    if (e_r >= s_r) disc = {16'd0, s2} + term_c;
    else disc = ({16'd0, s2} > term_c) ? {16'd0, s2} - term_c : '0;
  end

  assign step.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign spawn.valid = out_valid;
  assign spawn.spawn_age = age;
  assign spawn.last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and unit starts
  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = d_r;
    sq_start = 1'b0;
    unique case (state)
      ST_IDLE: if (step.valid && step.ready) state_next = ST_ACC;
      ST_ACC: begin
        if (update_valid && req_t'(in_type) == REQ_RAMP && d_r != '0) state_next = ST_BIRTH;
        else state_next = ST_IDLE;
      end
      ST_BIRTH: begin
        if (idx < limit && spawn_count < CW'(MAX_SPAWNS) && !out_valid) begin
          // num*512 / d gives q<<9 plus the remainder bits exactly
          dreq.start = 1'b1;
          dreq.num = {2'd0, num_d1, 9'd0};
          state_next = ST_DIV1;
        end else if (!(idx < limit && spawn_count < CW'(MAX_SPAWNS))) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV1: if (!dbusy) begin
        sq_start = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: state_next = ST_DEN;
      ST_DEN: if (!dbusy) state_next = ST_DIV2;
      ST_DIV2: begin
        if (den == '0) state_next = ST_EMIT;
        else begin
          dreq.start = 1'b1;
          dreq.num = {26'd0, n_val, 9'd0};
          dreq.den = den[31:0];
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: if (!dbusy) state_next = ST_BIRTH;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step_time <= MaxStepReset;
      birth_fraction <= '0;
      elapsed_time <= '0;
      spawn_count <= '0;
      update_valid <= 1'b0;
      held_dt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) max_step_time <= cfg.data;
      if (out_valid && spawn.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (step.valid && step.ready) begin
          s_r <= step.start_rate;
          e_r <= step.end_rate;
          d_r <= step.duration;
          prev <= birth_fraction;
          if (step.first_step) begin
            held_dt <= step.dt;
            elapsed_time <= '0;
            spawn_count <= '0;
            update_valid <= (step.dt != '0) && (step.dt <= max_step_time);
            if (!((step.dt != '0) && (step.dt <= max_step_time)))
              birth_fraction <= '0;
          end
          limit <= '0;
          idx <= '0;
        end
        ST_ACC: if (update_valid) begin
          if (req_t'(in_type) == REQ_RESET) begin
            birth_fraction <= '0;
            elapsed_time <= el_sum[32] ? '1 : el_sum[31:0];
          end else if (req_t'(in_type) == REQ_RAMP && d_r != '0) begin
            birth_fraction <= (acc >= {whole[25:0], 33'd0}) ?
                              24'((acc - {whole[25:0], 33'd0}) >> 9) : '0;
            limit <= lim_c;
            idx <= '0;
          end
        end
        ST_BIRTH: if (!(idx < limit && spawn_count < CW'(MAX_SPAWNS))) begin
          if (limit != '0 || (req_t'(in_type) == REQ_RAMP && d_r != '0 && update_valid))
            elapsed_time <= el_sum[32] ? '1 : el_sum[31:0];
        end
        ST_DEN: if (!dbusy) den <= {9'd0, s_r} + root[32:0];
        ST_EMIT: if (!dbusy) begin
          age <= ({1'b0, held_dt} > at) ? held_dt - at[31:0] : '0;
          last_r <= !((idx + CW'(1) < limit) && (spawn_count + CW'(1) < CW'(MAX_SPAWNS)));
          out_valid <= 1'b1;
          idx <= idx + CW'(1);
          spawn_count <= spawn_count + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // hold the request type of the step in work
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && step.valid && step.ready) in_type <= step.req_type;
  end

  // birth time clamp and absolute instant
  logic [31:0] t_c;
  always_comb begin
    if (den == '0) t_c = d_r;
    else if (quo > {63'd0, d_r}) t_c = d_r;
    else t_c = quo[31:0];
  end
  assign at = {1'b0, elapsed_time} + {1'b0, t_c};

  // remainder and the high root bits are not needed here
  logic unused_bits;
  assign unused_bits = ^{rem, root[63:33]};

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !spawn.ready |=> out_valid && $stable(age))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    spawn_count <= CW'(MAX_SPAWNS))
    else $error("spawn cap exceeded");
  assert property (@(posedge clk) disable iff (rst)
    step.ready |-> state == ST_IDLE)
    else $error("ready outside idle");
endmodule
